// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the sum-of-two-squares search.
// No dependencies; included by modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/core/sots_pkg.sv
// Package for the sum-of-two-squares search: shared types.
// No dependencies.
`default_nettype none
package sots_pkg;

	localparam int unsigned ValueW = 32;
	localparam int unsigned RootW  = 16;

	typedef struct packed {
		logic done;
		logic exact;
	} sots_sq_stat_t;

endpackage
`default_nettype wire

// File: rtl/core/sots_if.sv
// Valid/ready channel interfaces for the input value and the result.
// Depends on sots_pkg.
`default_nettype none
interface sots_value_if
	import sots_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [ValueW-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface sots_result_if
	import sots_pkg::*;
();
	logic             valid;
	logic             ready;
	logic             found;
	logic [RootW-1:0] small_root;
	logic [RootW-1:0] large_root;

	modport source (output valid, output found, output small_root, output large_root,
		input ready);
	modport sink   (input valid, input found, input small_root, input large_root,
		output ready);
endinterface
`default_nettype wire

// File: rtl/core/sots_isqrt.sv
// Iterative integer square root, two bits of operand per cycle.
// Depends on sots_pkg.
`default_nettype none
module sots_isqrt
	import sots_pkg::*;
#(
	parameter int unsigned VALUE_BITS = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [VALUE_BITS-1:0]         operand,
	output logic                               busy,
	output logic [(VALUE_BITS+1)/2-1:0]        root,
	output sots_sq_stat_t                      stat
);
	localparam int unsigned NB = VALUE_BITS;
	localparam int unsigned RB = (VALUE_BITS + 1) / 2;
	localparam logic [NB-1:0] TopProbe = NB'(1) << (2 * (RB - 1));

	logic [NB-1:0] rem_q, root_q, probe_q;
	logic          busy_q, done_q;
	logic [NB:0]   trial;
	logic          ge;

	assign trial = {1'b0, root_q} + {1'b0, probe_q};
	assign ge    = {1'b0, rem_q} >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			busy_q <= !probe_q[0];
			done_q <= probe_q[0];
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q   <= operand;
			root_q  <= '0;
			probe_q <= TopProbe;
		end else if (busy_q) begin
			if (ge) begin
				rem_q  <= rem_q - trial[NB-1:0];
				root_q <= (root_q >> 1) + probe_q;
			end else begin
				root_q <= root_q >> 1;
			end
			probe_q <= probe_q >> 2;
		end
	end

	assign busy       = busy_q;
	assign root       = root_q[RB-1:0];
	assign stat.done  = done_q;
	assign stat.exact = (rem_q == '0);
endmodule
`default_nettype wire

// File: rtl/core/sum_of_two_squares_search.sv
// Sum-of-two-squares search: smallest a with a*a + b*b = value, a <= b.
// The bound a <= isqrt(value/2) and each candidate's b = isqrt(value - a*a) both come
// from the shared square-root unit, which works on one operand at a time.
// One transaction in flight; next input taken the cycle after the result is handed to
// the output register. Asynchronous active-low reset clears control state only.
`default_nettype none
module sum_of_two_squares_search
	import sots_pkg::*;
#(
	parameter int unsigned VALUE_BITS = 32
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	sots_value_if.sink    item,
	sots_result_if.source result
);
	`include "assert_macros.svh"

	localparam int unsigned NB = VALUE_BITS;
	localparam int unsigned RB = (VALUE_BITS + 1) / 2;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_LIMIT  = 3'd1;
	localparam logic [2:0] ST_LAUNCH = 3'd2;
	localparam logic [2:0] ST_SEARCH = 3'd3;
	localparam logic [2:0] ST_FIN    = 3'd4;

	logic [2:0]       state_q;
	logic [NB-1:0]    n_q, sq_q, n_in;
	logic [RB-1:0]    limit_q, a_q, sq_root;
	logic             res_found_q;
	logic [RB-1:0]    res_b_q;
	logic             out_valid_q, out_found_q;
	logic [RootW-1:0] out_small_q, out_large_q;
	logic             accept, sq_start, sq_busy, hit, out_load;
	logic [NB-1:0]    sq_operand;
	sots_sq_stat_t    sq_stat;

	assign n_in   = NB'(item.value);
	assign accept = item.valid && item.ready;
	assign item.ready = (state_q == ST_IDLE);

	assign sq_start   = accept || (state_q == ST_LAUNCH);
	assign sq_operand = (state_q == ST_LAUNCH) ? (n_q - sq_q) : (n_in >> 1);
	assign hit        = sq_stat.exact && (sq_root >= a_q);
	assign out_load   = (state_q == ST_FIN) && (!out_valid_q || result.ready);

	sots_isqrt #(.VALUE_BITS(VALUE_BITS)) u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sq_start),
		.operand (sq_operand),
		.busy    (sq_busy),
		.root    (sq_root),
		.stat    (sq_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_LIMIT;
				ST_LIMIT: if (sq_stat.done) state_q <= ST_LAUNCH;
				ST_LAUNCH: state_q <= ST_SEARCH;
				ST_SEARCH: begin
					if (sq_stat.done) begin
						state_q <= (hit || a_q == limit_q) ? ST_FIN : ST_LAUNCH;
					end
				end
				ST_FIN: if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) n_q <= n_in;
		if (state_q == ST_LIMIT && sq_stat.done) begin
			limit_q <= sq_root;
			a_q     <= '0;
			sq_q    <= '0;
		end
		if (state_q == ST_SEARCH && sq_stat.done) begin
			res_found_q <= hit;
			res_b_q     <= sq_root;
			if (!hit && a_q != limit_q) begin
				// (a+1)^2 = a^2 + 2a + 1
				sq_q <= sq_q + NB'({a_q, 1'b1});
				a_q  <= a_q + 1'b1;
			end
		end
		if (out_load) begin
			out_found_q <= res_found_q;
			out_small_q <= res_found_q ? RootW'(a_q) : '0;
			out_large_q <= res_found_q ? RootW'(res_b_q) : '0;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.found      = out_found_q;
	assign result.small_root = out_small_q;
	assign result.large_root = out_large_q;

	`ASSERT_SAME(a_within_bound, clk, arst_n,
		(state_q == ST_LAUNCH || state_q == ST_SEARCH), (a_q <= limit_q))
	`ASSERT_SAME(root_unit_idle, clk, arst_n,
		(state_q == ST_IDLE || state_q == ST_FIN), (!sq_busy))
	`ASSERT_NEXT(accept_starts_bound, clk, arst_n,
		accept, (state_q == ST_LIMIT && sq_busy))
endmodule
`default_nettype wire
